// ===== rtl/vfsc_pkg.sv =====
`default_nettype none

package vfsc_pkg;

	localparam int TABLE_STEPS_DEF  = 30;
	localparam int LINEAR_STEPS_DEF = 256;
	localparam int ROM_LAST         = 30;

	localparam int CODE_W    = 10;
	localparam int POS_W     = 9;
	localparam int WORD_W    = 16;
	localparam int STEPS_W   = 16;
	localparam int DIFF_W    = 8;
	localparam int INF_W     = 15;
	localparam int DMAG_W    = 16;
	localparam int X_W       = DIFF_W + DMAG_W;
	localparam int IDX_W     = 5;
	localparam int DEST_W    = 18;
	localparam int CFG_IDX_W = 3;

	localparam logic [CODE_W-1:0] CODE_MAX = 10'd1023;
	localparam int LINEAR_SHIFT = 2;

	localparam logic [WORD_W-1:0] DEV_FIRST  = 16'd160;
	localparam logic [WORD_W-1:0] DEV_SECOND = 16'd60;

	localparam logic [1:0] MODE_NEAR    = 2'd0;
	localparam logic [1:0] MODE_FAR     = 2'd1;
	localparam logic [1:0] MODE_INIT    = 2'd2;
	localparam logic [1:0] MODE_ILLEGAL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RAWCHIP_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VENDOR_FIRST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OTP_INFINITY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OTP_MACRO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAWCHIP_START = 3'd4;

	localparam logic [CODE_W-1:0] ROM_FIRST [0:ROM_LAST] = '{
		10'd304, 10'd309, 10'd314, 10'd319, 10'd324, 10'd329, 10'd333, 10'd339,
		10'd344, 10'd350, 10'd355, 10'd361, 10'd366, 10'd372, 10'd378, 10'd385,
		10'd391, 10'd399, 10'd406, 10'd416, 10'd425, 10'd436, 10'd446, 10'd485,
		10'd469, 10'd482, 10'd494, 10'd508, 10'd522, 10'd537, 10'd552};

	localparam logic [CODE_W-1:0] ROM_SECOND [0:ROM_LAST] = '{
		10'd225, 10'd229, 10'd233, 10'd237, 10'd241, 10'd245, 10'd249, 10'd254,
		10'd258, 10'd263, 10'd267, 10'd272, 10'd276, 10'd281, 10'd286, 10'd291,
		10'd296, 10'd303, 10'd309, 10'd317, 10'd324, 10'd333, 10'd341, 10'd351,
		10'd360, 10'd371, 10'd381, 10'd393, 10'd404, 10'd417, 10'd429};

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [STEPS_W-1:0] step_count;
	} cmd_t;

	typedef struct packed {
		logic              write_valid;
		logic [CODE_W-1:0] dac_code;
		logic [POS_W-1:0]  step_position;
		logic              status;
	} res_t;

	typedef struct packed {
		logic              rawchip;
		logic              first;
		logic              calibrated;
		logic [INF_W-1:0]  cal_inf;
		logic              dneg;
		logic [DMAG_W-1:0] dmag;
		logic [CODE_W-1:0] start;
	} cfg_t;

	typedef struct packed {
		logic              write_valid;
		logic              status;
		logic [POS_W-1:0]  pos;
		logic              scale;
		logic [CODE_W-1:0] direct_code;
		logic [DIFF_W-1:0] diff;
	} trk_t;

	function automatic logic [CODE_W-1:0] rom_code(input logic first,
			input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] i;
		i = (idx > IDX_W'(ROM_LAST)) ? IDX_W'(ROM_LAST) : idx;
		return first ? ROM_FIRST[i] : ROM_SECOND[i];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/vfsc_cfg_regs.sv =====
`default_nettype none

module vfsc_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vfsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vfsc_pkg::WORD_W-1:0]       cfg_data,
	output vfsc_pkg::cfg_t                         cfg
);

	logic                            rawchip_q;
	logic                            first_q;
	logic [vfsc_pkg::WORD_W-1:0]     inf_word_q;
	logic [vfsc_pkg::WORD_W-1:0]     macro_word_q;
	logic [vfsc_pkg::CODE_W-1:0]     start_q;

	logic [vfsc_pkg::WORD_W-1:0]     dev;
	logic [vfsc_pkg::INF_W-1:0]      inf;
	logic [vfsc_pkg::WORD_W-1:0]     inf_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rawchip_q    <= 1'b1;
			first_q      <= 1'b0;
			inf_word_q   <= '0;
			macro_word_q <= '0;
			start_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vfsc_pkg::REG_RAWCHIP_MODE:  rawchip_q    <= cfg_data[0];
				vfsc_pkg::REG_VENDOR_FIRST:  first_q      <= cfg_data[0];
				vfsc_pkg::REG_OTP_INFINITY:  inf_word_q   <= cfg_data;
				vfsc_pkg::REG_OTP_MACRO:     macro_word_q <= cfg_data;
				vfsc_pkg::REG_RAWCHIP_START: start_q      <= cfg_data[vfsc_pkg::CODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Calibrated infinity: the word read as signed, less the vendor deviation, floored at 0.
	always_comb begin
		dev = first_q ? vfsc_pkg::DEV_FIRST : vfsc_pkg::DEV_SECOND;
		priority if (inf_word_q[vfsc_pkg::WORD_W-1]) begin
			inf = '0;
		end else if (inf_word_q > dev) begin
			inf = vfsc_pkg::INF_W'(inf_word_q - dev);
		end else begin
			inf = '0;
		end
		inf_ext = vfsc_pkg::WORD_W'(inf);

		cfg.rawchip    = rawchip_q;
		cfg.first      = first_q;
		cfg.calibrated = (|inf_word_q) || (|macro_word_q);
		cfg.cal_inf    = inf;
		cfg.dneg       = macro_word_q < inf_ext;
		cfg.dmag       = cfg.dneg ? (inf_ext - macro_word_q) : (macro_word_q - inf_ext);
		cfg.start      = start_q;
	end

endmodule

`default_nettype wire

// ===== rtl/vfsc_step_track.sv =====
`default_nettype none

module vfsc_step_track #(
	parameter int TABLE_STEPS  = vfsc_pkg::TABLE_STEPS_DEF,
	parameter int LINEAR_STEPS = vfsc_pkg::LINEAR_STEPS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire vfsc_pkg::cmd_t cmd,
	input  wire vfsc_pkg::cfg_t cfg,
	input  wire logic           take,
	output logic                trk_valid,
	output vfsc_pkg::trk_t      trk
);

	localparam int DW = vfsc_pkg::DEST_W;
	localparam int PW = vfsc_pkg::POS_W;
	localparam int CW = vfsc_pkg::CODE_W;
	localparam logic signed [DW-1:0] TOTAL_TABLE  = DW'(TABLE_STEPS);
	localparam logic signed [DW-1:0] TOTAL_LINEAR = DW'(LINEAR_STEPS);

	logic                 v_s1;
	vfsc_pkg::cmd_t       cmd_s1;
	logic                 v_s2;
	vfsc_pkg::trk_t       trk_s2;
	logic [PW-1:0]        cur_q;

	logic                 rdy_s1;
	logic                 rdy_s2;
	logic signed [DW-1:0] n_ext;
	logic signed [DW-1:0] delta;
	logic signed [DW-1:0] dest;
	logic signed [DW-1:0] total;
	logic [PW-1:0]        target;
	logic [vfsc_pkg::IDX_W-1:0] idx;
	logic [CW-1:0]        lin;
	logic [CW-1:0]        rom;
	logic [CW-1:0]        rom0;
	vfsc_pkg::trk_t       nxt;

	assign rdy_s2    = !v_s2 || take;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd_stall = !rdy_s1;
	assign trk_valid = v_s2;
	assign trk       = trk_s2;

	always_comb begin
		n_ext = {{(DW - vfsc_pkg::STEPS_W){cmd_s1.step_count[vfsc_pkg::STEPS_W-1]}},
			cmd_s1.step_count};
		delta = (cmd_s1.mode == vfsc_pkg::MODE_NEAR) ? n_ext : -n_ext;
		dest  = $signed({{(DW - PW){1'b0}}, cur_q}) + delta;
		total = cfg.rawchip ? TOTAL_LINEAR : TOTAL_TABLE;
		priority if (dest < 0) begin
			target = '0;
		end else if (dest > total) begin
			target = PW'(total);
		end else begin
			target = PW'(dest);
		end

		nxt = '0;
		unique case (cmd_s1.mode)
			vfsc_pkg::MODE_INIT: begin
				nxt.write_valid = 1'b1;
				nxt.pos         = '0;
			end
			vfsc_pkg::MODE_ILLEGAL: begin
				nxt.status = 1'b1;
				nxt.pos    = cur_q;
			end
			default: begin
				nxt.write_valid = (target != cur_q);
				nxt.pos         = target;
			end
		endcase

		// Table positions never exceed the table length, so the ROM index only saturates
		// when the table is longer than the ROM.
		idx  = (nxt.pos > PW'(vfsc_pkg::ROM_LAST)) ? vfsc_pkg::IDX_W'(vfsc_pkg::ROM_LAST)
			: nxt.pos[vfsc_pkg::IDX_W-1:0];
		lin  = cfg.start + CW'((PW + vfsc_pkg::LINEAR_SHIFT)'(nxt.pos) << vfsc_pkg::LINEAR_SHIFT);
		rom  = vfsc_pkg::rom_code(cfg.first, idx);
		rom0 = vfsc_pkg::rom_code(cfg.first, '0);
		priority if (cfg.rawchip) begin
			nxt.direct_code = lin;
		end else if (nxt.pos == '0) begin
			nxt.direct_code = cfg.calibrated ? cfg.cal_inf[CW-1:0] : rom0;
		end else if (cfg.calibrated) begin
			nxt.scale = 1'b1;
			nxt.diff  = vfsc_pkg::DIFF_W'(rom - rom0);
		end else begin
			nxt.direct_code = rom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			cur_q <= '0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= cmd_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
				if (v_s1) begin
					cur_q <= nxt.pos;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && rdy_s1) begin
			cmd_s1 <= cmd;
		end
		if (v_s1 && rdy_s2) begin
			trk_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vfsc_code_calc.sv =====
`default_nettype none

module vfsc_code_calc #(
	parameter int TABLE_STEPS = vfsc_pkg::TABLE_STEPS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        trk_valid,
	input  wire vfsc_pkg::trk_t              trk,
	output logic                             take,
	input  wire vfsc_pkg::cfg_t              cfg,
	input  wire logic                        out_rdy,
	output logic                             calc_valid,
	output vfsc_pkg::trk_t                   calc,
	output logic [vfsc_pkg::X_W-1:0]         q
);

	localparam int XW   = vfsc_pkg::X_W;
	localparam int LAST = (TABLE_STEPS > vfsc_pkg::ROM_LAST) ? vfsc_pkg::ROM_LAST : TABLE_STEPS;
	localparam int SPAN_FIRST  = int'(vfsc_pkg::ROM_FIRST[LAST]) - int'(vfsc_pkg::ROM_FIRST[0]);
	localparam int SPAN_SECOND = int'(vfsc_pkg::ROM_SECOND[LAST]) - int'(vfsc_pkg::ROM_SECOND[0]);
	localparam int SPAN_MAX = (SPAN_FIRST > SPAN_SECOND) ? SPAN_FIRST : SPAN_SECOND;
	localparam int SPAN_MIN = (SPAN_FIRST > SPAN_SECOND) ? SPAN_SECOND : SPAN_FIRST;
	// With the shift at least the dividend width plus the divisor's bit length, the
	// rounded-up reciprocal gives the exact floor for every dividend below 2**XW.
	localparam int SHIFT     = XW + $clog2(SPAN_MAX);
	localparam int FLOOR_MIN = $clog2(SPAN_MIN + 1) - 1;
	localparam int RECIP_W   = SHIFT - FLOOR_MIN + 1;
	localparam int PROD_W    = XW + RECIP_W;
	localparam logic [63:0] ONE_SHIFTED  = 64'd1 << SHIFT;
	localparam logic [63:0] RECIP_FIRST  =
		(ONE_SHIFTED + 64'(SPAN_FIRST) - 64'd1) / 64'(SPAN_FIRST);
	localparam logic [63:0] RECIP_SECOND =
		(ONE_SHIFTED + 64'(SPAN_SECOND) - 64'd1) / 64'(SPAN_SECOND);

	logic                v_s3;
	vfsc_pkg::trk_t      trk_s3;
	logic [XW-1:0]       x_s3;
	logic                v_s4;
	vfsc_pkg::trk_t      trk_s4;
	logic [XW-1:0]       q_s4;

	logic                rdy_s3;
	logic                rdy_s4;
	logic [XW-1:0]       x_nxt;
	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   prod;

	assign rdy_s4     = !v_s4 || out_rdy;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign take       = rdy_s3;
	assign calc_valid = v_s4;
	assign calc       = trk_s4;
	assign q          = q_s4;

	always_comb begin
		x_nxt = XW'(trk.diff) * XW'(cfg.dmag);
		recip = cfg.first ? RECIP_W'(RECIP_FIRST) : RECIP_W'(RECIP_SECOND);
		prod  = PROD_W'(x_s3) * PROD_W'(recip);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= trk_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trk_valid && rdy_s3) begin
			trk_s3 <= trk;
			x_s3   <= x_nxt;
		end
		if (v_s3 && rdy_s4) begin
			trk_s4 <= trk_s3;
			q_s4   <= XW'(prod[PROD_W-1:SHIFT]);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vcm_focus_step_controller.sv =====
`default_nettype none

// Channel   Direction  Handshake              Word
// cmd       in         cmd_valid / cmd_stall  vfsc_pkg::cmd_t (mode, step_count)
// res       out        res_valid / res_stall  vfsc_pkg::res_t (write_valid .. status)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A command word takes five register stages: input, position update and code lookup,
// offset times calibrated range, reciprocal multiply for the divide by the table span,
// then the final add, clamp and result register. One word per cycle is sustained while
// res_stall is low, and the position register is updated in the second stage so that
// back-to-back moves see each other. Reset loads the register defaults (raw-chip mode
// on) and position zero; there is no clearing pass. cmd_stall rises only when every
// stage holds a word and the result is stalled.

module vcm_focus_step_controller #(
	parameter int TABLE_STEPS  = vfsc_pkg::TABLE_STEPS_DEF,
	parameter int LINEAR_STEPS = vfsc_pkg::LINEAR_STEPS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire vfsc_pkg::cmd_t                 cmd,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output vfsc_pkg::res_t                      res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [vfsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vfsc_pkg::WORD_W-1:0]    cfg_data
);

	localparam int CW     = vfsc_pkg::CODE_W;
	localparam int V_W    = vfsc_pkg::X_W + 2;
	localparam int POS_TOP = (TABLE_STEPS > LINEAR_STEPS) ? TABLE_STEPS : LINEAR_STEPS;

	vfsc_pkg::cfg_t          cfg;
	logic                    trk_valid;
	vfsc_pkg::trk_t          trk;
	logic                    take;
	logic                    calc_valid;
	vfsc_pkg::trk_t          calc;
	logic [vfsc_pkg::X_W-1:0] q;
	logic                    out_rdy;

	logic                    res_valid_q;
	vfsc_pkg::res_t          res_q;
	logic [V_W-1:0]          vsum;
	logic [CW-1:0]           scaled;
	vfsc_pkg::res_t          res_nxt;

	vfsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	vfsc_step_track #(
		.TABLE_STEPS  (TABLE_STEPS),
		.LINEAR_STEPS (LINEAR_STEPS)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cfg       (cfg),
		.take      (take),
		.trk_valid (trk_valid),
		.trk       (trk)
	);

	vfsc_code_calc #(
		.TABLE_STEPS (TABLE_STEPS)
	) u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.trk_valid  (trk_valid),
		.trk        (trk),
		.take       (take),
		.cfg        (cfg),
		.out_rdy    (out_rdy),
		.calc_valid (calc_valid),
		.calc       (calc),
		.q          (q)
	);

	assign out_rdy   = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The quotient is truncated toward zero, so the sign of the range is applied afterwards.
	always_comb begin
		vsum = cfg.dneg ? (V_W'(cfg.cal_inf) - V_W'(q)) : (V_W'(cfg.cal_inf) + V_W'(q));
		priority if (vsum[V_W-1]) begin
			scaled = '0;
		end else if (vsum > V_W'(vfsc_pkg::CODE_MAX)) begin
			scaled = vfsc_pkg::CODE_MAX;
		end else begin
			scaled = vsum[CW-1:0];
		end

		res_nxt.write_valid   = calc.write_valid;
		res_nxt.step_position = calc.pos;
		res_nxt.status        = calc.status;
		if (calc.write_valid) begin
			res_nxt.dac_code = calc.scale ? scaled : calc.direct_code;
		end else begin
			res_nxt.dac_code = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_rdy) begin
			res_valid_q <= calc_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (calc_valid && out_rdy) begin
			res_q <= res_nxt;
		end
	end

	a_no_code_without_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.write_valid |-> res.dac_code == '0)
		else $error("dac code set on a word without a DAC write");

	a_rejected_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> !res.write_valid)
		else $error("rejected command issued a DAC write");

	a_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.step_position <= vfsc_pkg::POS_W'(POS_TOP))
		else $error("step position beyond the longest step range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !cmd_stall)
		else $error("command stalled while the result register is empty");

endmodule

`default_nettype wire
